[rtl/lpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lpm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int PATTERN_BYTES   = 32;
  localparam int NUM_WORDS       = 4;
  localparam int WORD_W          = 64;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int LEN_REG_W       = 6;
  localparam int OUT_CNT_W       = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd6;

  localparam logic [1:0] MODE_EXACT    = 2'd0;
  localparam logic [1:0] MODE_CONTAINS = 2'd1;
  localparam logic [1:0] MODE_PREFIX   = 2'd2;
  localparam logic [1:0] MODE_SUFFIX   = 2'd3;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } item_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      r = b + ASCII_CASE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/lpm_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpm_cfg #(
  parameter int MAX_PATTERN = lpm_pkg::MAX_PATTERN_DEF,
  localparam int LEN_MAX = (MAX_PATTERN < lpm_pkg::PATTERN_BYTES) ?
                           MAX_PATTERN : lpm_pkg::PATTERN_BYTES,
  localparam int LEN_W   = $clog2(LEN_MAX + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lpm_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  output logic [1:0]                             mode,
  output logic                                   fold_en,
  output logic [LEN_W-1:0]                       pat_len,
  output logic [LEN_MAX-1:0][7:0]                pat_fwd,
  output logic [LEN_MAX-1:0][7:0]                pat_tail,
  output logic [LEN_MAX-1:0]                     pat_tail_en
);
  import lpm_pkg::*;

  logic [1:0]                   mode_r;
  logic                         fold_r;
  logic [LEN_REG_W-1:0]         len_r;
  logic [NUM_WORDS-1:0][WORD_W-1:0] word_r;

  logic [LEN_W-1:0]             len_r2, len_nxt;
  logic [LEN_MAX-1:0][7:0]      fwd_r, fwd_nxt;
  logic [LEN_MAX-1:0][7:0]      tail_r, tail_nxt;
  logic [LEN_MAX-1:0]           tail_en_r, tail_en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CONTAINS;
      fold_r <= 1'b0;
      len_r  <= '0;
      word_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MATCH_MODE:     mode_r    <= cfg_wr_data[1:0];
        CFG_CASE_FOLD:      fold_r    <= cfg_wr_data[0];
        CFG_PATTERN_LENGTH: len_r     <= cfg_wr_data[LEN_REG_W-1:0];
        CFG_PATTERN_WORD_0: word_r[0] <= cfg_wr_data[WORD_W-1:0];
        CFG_PATTERN_WORD_1: word_r[1] <= cfg_wr_data[WORD_W-1:0];
        CFG_PATTERN_WORD_2: word_r[2] <= cfg_wr_data[WORD_W-1:0];
        CFG_PATTERN_WORD_3: word_r[3] <= cfg_wr_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // derived pattern views, refreshed every cycle from the registers
  always_comb begin
    if (len_r > LEN_REG_W'(LEN_MAX)) begin
      len_nxt = LEN_W'(LEN_MAX);
    end else begin
      len_nxt = LEN_W'(len_r);
    end
    for (int i = 0; i < LEN_MAX; i++) begin
      fwd_nxt[i] = fold_byte(word_r[i >> 3][(i & 7) * 8 +: 8], fold_r);
    end
    // tail view: entry w holds pattern byte len-1-w, aligned to the window
    for (int w = 0; w < LEN_MAX; w++) begin
      tail_nxt[w]    = 8'h00;
      tail_en_nxt[w] = (w < int'(len_nxt));
      for (int k = 0; k < LEN_MAX; k++) begin
        if (w + k + 1 == int'(len_nxt)) begin
          tail_nxt[w] = fwd_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r2    <= '0;
      tail_en_r <= '0;
    end else begin
      len_r2    <= len_nxt;
      tail_en_r <= tail_en_nxt;
    end
    fwd_r  <= fwd_nxt;
    tail_r <= tail_nxt;
  end

  assign mode        = mode_r;
  assign fold_en     = fold_r;
  assign pat_len     = len_r2;
  assign pat_fwd     = fwd_r;
  assign pat_tail    = tail_r;
  assign pat_tail_en = tail_en_r;

endmodule
`default_nettype wire

[rtl/lpm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpm_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_text_byte,
  input  wire logic           in_no_byte,
  input  wire logic           in_last,
  input  wire logic           fold_en,
  input  wire logic           q_full,
  output logic                q_push,
  output lpm_pkg::item_t      q_item
);
  import lpm_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept, keep;

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  // an item with no byte and no end of text does nothing: drop it here
  assign keep     = !in_no_byte || in_last;

  always_comb begin
    if (accept && keep) begin
      valid_nxt = 1'b1;
    end else if (q_full) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept && keep) begin
      item_r.data     <= fold_byte(in_text_byte, fold_en);
      item_r.has_byte <= !in_no_byte;
      item_r.last     <= in_last;
    end
  end

  assign q_push = valid_r && !q_full;
  assign q_item = item_r;

endmodule
`default_nettype wire

[rtl/lpm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lpm_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output lpm_pkg::item_t      head_item
);
  import lpm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (pop) begin
        rd_r <= ptr_inc(rd_r);
      end
    end
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/lpm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpm_back #(
  parameter int MAX_PATTERN = lpm_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH = lpm_pkg::COUNT_WIDTH_DEF,
  localparam int LEN_MAX = (MAX_PATTERN < lpm_pkg::PATTERN_BYTES) ?
                           MAX_PATTERN : lpm_pkg::PATTERN_BYTES,
  localparam int LEN_W   = $clog2(LEN_MAX + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire lpm_pkg::item_t                head_item,
  output logic                               pop,
  input  wire logic [1:0]                    mode,
  input  wire logic [LEN_W-1:0]              pat_len,
  input  wire logic [LEN_MAX-1:0][7:0]       pat_fwd,
  input  wire logic [LEN_MAX-1:0][7:0]       pat_tail,
  input  wire logic [LEN_MAX-1:0]            pat_tail_en,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_matched,
  output logic [lpm_pkg::OUT_CNT_W-1:0]      out_evaluations,
  output logic [lpm_pkg::OUT_CNT_W-1:0]      out_matches_res
);
  import lpm_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PATTERN + 2);
  localparam int IDX_W  = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
  localparam int OUT_W  = (COUNT_WIDTH < OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  logic [MAX_PATTERN-1:0][7:0] win_r, win_nxt;
  logic [SEEN_W-1:0]           seen_r, seen_nxt;
  logic                        prefix_r, prefix_nxt;
  logic                        found_r, found_nxt;
  logic [COUNT_WIDTH-1:0]      eval_r, eval_nxt;
  logic [COUNT_WIDTH-1:0]      match_r, match_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_matched_r;
  logic [OUT_CNT_W-1:0]        out_eval_r, out_match_r;
  logic [OUT_CNT_W-1:0]        eval_ext, match_ext;

  logic [SEEN_W-1:0]           len_ext;
  logic                        tail_ok, verdict, finish;

  assign len_ext = SEEN_W'(pat_len);
  assign pop     = head_valid && (!head_item.last || !out_valid_r || !out_stall);
  assign finish  = pop && head_item.last;

  always_comb begin
    win_nxt    = win_r;
    seen_nxt   = seen_r;
    prefix_nxt = prefix_r;
    if (head_item.has_byte) begin
      win_nxt[0] = head_item.data;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      if (seen_r < len_ext && head_item.data != pat_fwd[seen_r[IDX_W-1:0]]) begin
        prefix_nxt = 1'b0;
      end
      if (seen_r < SEEN_W'(MAX_PATTERN + 1)) begin
        seen_nxt = seen_r + 1'b1;
      end
    end

    // newest pattern-length bytes against the aligned pattern
    tail_ok = (seen_nxt >= len_ext);
    for (int w = 0; w < LEN_MAX; w++) begin
      if (pat_tail_en[w] && win_nxt[w] != pat_tail[w]) begin
        tail_ok = 1'b0;
      end
    end
    found_nxt = found_r || (head_item.has_byte && tail_ok);

    unique case (mode)
      MODE_EXACT:    verdict = (seen_nxt == len_ext) && prefix_nxt;
      MODE_CONTAINS: verdict = (pat_len == '0) || found_nxt;
      MODE_PREFIX:   verdict = (seen_nxt >= len_ext) && prefix_nxt;
      MODE_SUFFIX:   verdict = tail_ok;
      default:       verdict = 1'b0;
    endcase

    eval_nxt  = eval_r + 1'b1;
    match_nxt = verdict ? match_r + 1'b1 : match_r;

    eval_ext  = '0;
    match_ext = '0;
    eval_ext[OUT_W-1:0]  = eval_nxt[OUT_W-1:0];
    match_ext[OUT_W-1:0] = match_nxt[OUT_W-1:0];

    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      prefix_r    <= 1'b1;
      found_r     <= 1'b0;
      eval_r      <= '0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        seen_r   <= '0;
        prefix_r <= 1'b1;
        found_r  <= 1'b0;
        eval_r   <= eval_nxt;
        match_r  <= match_nxt;
      end else if (pop) begin
        seen_r   <= seen_nxt;
        prefix_r <= prefix_nxt;
        found_r  <= found_nxt;
      end
    end
    if (pop) begin
      win_r <= win_nxt;
    end
    if (finish) begin
      out_matched_r <= verdict;
      out_eval_r    <= eval_ext;
      out_match_r   <= match_ext;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_evaluations = out_eval_r;
  assign out_matches_res = out_match_r;

endmodule
`default_nettype wire

[rtl/literal_pattern_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// Streams a text one byte per item and matches it against a literal pattern of up
// to 32 bytes (exact, contains, prefix or suffix, optional ASCII case folding).
// One item is accepted every cycle unless in_stall is raised: the front register
// folds the byte, a two-entry queue decouples it from the back end, whose window
// compare runs against a pre-aligned copy of the pattern. The result for a text
// is registered after its last item has passed the front register and the queue
// and is held until taken; while it waits, bytes of the next text keep flowing.
// Items with no byte and no last flag are dropped. Pattern writes are re-aligned.
module literal_pattern_matcher #(
  parameter int MAX_PATTERN = lpm_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH = lpm_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_text_byte,
  input  wire logic                            in_no_byte,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_matched,
  output logic [lpm_pkg::OUT_CNT_W-1:0]        out_evaluations,
  output logic [lpm_pkg::OUT_CNT_W-1:0]        out_matches_res,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import lpm_pkg::*;

  localparam int LEN_MAX = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);

  logic [1:0]              mode;
  logic                    fold_en;
  logic [LEN_W-1:0]        pat_len;
  logic [LEN_MAX-1:0][7:0] pat_fwd;
  logic [LEN_MAX-1:0][7:0] pat_tail;
  logic [LEN_MAX-1:0]      pat_tail_en;

  logic  q_full, q_push, q_pop, head_valid;
  item_t q_item, head_item;

  lpm_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .mode        (mode),
    .fold_en     (fold_en),
    .pat_len     (pat_len),
    .pat_fwd     (pat_fwd),
    .pat_tail    (pat_tail),
    .pat_tail_en (pat_tail_en)
  );

  lpm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_no_byte   (in_no_byte),
    .in_last      (in_last),
    .fold_en      (fold_en),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  lpm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lpm_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (q_pop),
    .mode            (mode),
    .pat_len         (pat_len),
    .pat_fwd         (pat_fwd),
    .pat_tail        (pat_tail),
    .pat_tail_en     (pat_tail_en),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_matched     (out_matched),
    .out_evaluations (out_evaluations),
    .out_matches_res (out_matches_res)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import lpm_pkg::*;

  localparam int NUM_BLOCKS  = 16;
  localparam int BLOCK_ITEMS = 62;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        matched;
    logic [31:0] evaluations;
    logic [31:0] matches_res;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_text_byte = 8'h00;
  logic                  in_no_byte = 1'b0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_matched;
  logic [OUT_CNT_W-1:0]  out_evaluations;
  logic [OUT_CNT_W-1:0]  out_matches_res;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MATCH_MODE;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // matcher state as the testbench sees it
  logic [1:0]  mode_q = MODE_CONTAINS;
  logic        fold_q = 1'b0;
  logic [5:0]  len_q = '0;
  logic [63:0] word_q [NUM_WORDS];
  logic [7:0]  window_q [MAX_PATTERN_DEF];
  int          seen_q = 0;
  logic        prefix_q = 1'b1;
  logic        found_q = 1'b0;
  logic [31:0] eval_q = '0;
  logic [31:0] hit_q = '0;

  verdict_t    verdicts_due [$];
  verdict_t    due;
  logic [7:0]  text_buf [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;

  literal_pattern_matcher uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_no_byte      (in_no_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_matched     (out_matched),
    .out_evaluations (out_evaluations),
    .out_matches_res (out_matches_res),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no text pending");
        fail_count++;
      end else begin
        due = verdicts_due.pop_front();
        if (out_matched !== due.matched) begin
          $error("matched: expected %0d, got %0d", due.matched, out_matched);
          fail_count++;
        end
        if (out_evaluations !== due.evaluations) begin
          $error("evaluations: expected %0d, got %0d", due.evaluations, out_evaluations);
          fail_count++;
        end
        if (out_matches_res !== due.matches_res) begin
          $error("matches_res: expected %0d, got %0d", due.matches_res, out_matches_res);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [7:0] folded(input logic [7:0] c);
    if (fold_q && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c + ASCII_CASE;
    return c;
  endfunction

  function automatic int pattern_size();
    return (len_q > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len_q);
  endfunction

  function automatic logic [7:0] raw_pattern(input int k);
    return word_q[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic logic tail_hit(input int n);
    if (seen_q < n) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (window_q[n - 1 - k] != folded(raw_pattern(k))) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic update_match_state(input logic [7:0] b, input logic nb, input logic lst);
    int       n;
    logic     hit;
    logic [7:0] c;
    verdict_t v;
    n = pattern_size();
    if (!nb) begin
      c = folded(b);
      for (int i = MAX_PATTERN_DEF - 1; i > 0; i--) window_q[i] = window_q[i - 1];
      window_q[0] = c;
      if (seen_q < n && c != folded(raw_pattern(seen_q))) prefix_q = 1'b0;
      if (seen_q < MAX_PATTERN_DEF + 1) seen_q++;
      if (tail_hit(n)) found_q = 1'b1;
    end
    if (lst) begin
      case (mode_q)
        MODE_EXACT:    hit = (seen_q == n) && prefix_q;
        MODE_CONTAINS: hit = (n == 0) || found_q;
        MODE_PREFIX:   hit = (seen_q >= n) && prefix_q;
        default:       hit = tail_hit(n);
      endcase
      eval_q++;
      if (hit) hit_q++;
      v.matched = hit;
      v.evaluations = eval_q;
      v.matches_res = hit_q;
      verdicts_due.push_back(v);
      seen_q = 0;
      prefix_q = 1'b1;
      found_q = 1'b0;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic nb, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_no_byte <= nb;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    update_match_state(b, nb, lst);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MATCH_MODE:     mode_q = val[1:0];
      CFG_CASE_FOLD:      fold_q = val[0];
      CFG_PATTERN_LENGTH: len_q = val[5:0];
      CFG_PATTERN_WORD_0: word_q[0] = val;
      CFG_PATTERN_WORD_1: word_q[1] = val;
      CFG_PATTERN_WORD_2: word_q[2] = val;
      CFG_PATTERN_WORD_3: word_q[3] = val;
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk, which must be ignored
  task automatic load_config(input logic [1:0] mode, input logic fold, input logic [5:0] len,
                             input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    wait_idle();
    write_reg(CFG_MATCH_MODE, {junk[63:2], mode});
    write_reg(CFG_CASE_FOLD, {junk[63:1], fold});
    write_reg(CFG_PATTERN_LENGTH, {junk[63:6], len});
    write_reg(CFG_PATTERN_WORD_0, w0);
    write_reg(CFG_PATTERN_WORD_1, w1);
    write_reg(CFG_PATTERN_WORD_2, w2);
    write_reg(CFG_PATTERN_WORD_3, w3);
    cfg_wr_en <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = ($urandom_range(3) == 0) ? ASCII_UPPER_Z : ASCII_UPPER_A + 8'($urandom_range(2));
    return $urandom_range(1) ? base : base + ASCII_CASE;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic is_alpha;
    is_alpha = (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ||
               (c >= ASCII_UPPER_A + ASCII_CASE && c <= ASCII_UPPER_Z + ASCII_CASE);
    return (is_alpha && $urandom_range(1)) ? c ^ ASCII_CASE : c;
  endfunction

  function automatic logic [7:0] near_letter();
    int n;
    n = pattern_size();
    if (n > 0 && $urandom_range(1)) return flip_case(raw_pattern($urandom_range(n - 1)));
    return pick_letter();
  endfunction

  // mostly pattern-bearing texts, some long, some mutated, some noise or empty
  task automatic build_text();
    int n;
    int kind;
    int goal;
    n = pattern_size();
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 6) return;
    if (kind < 18) begin
      repeat ($urandom_range(6, 1)) text_buf.push_back(8'($urandom_range(255)));
      return;
    end
    goal = (kind < 28) ? MAX_PATTERN_DEF + 1 + $urandom_range(7) : 0;
    repeat ($urandom_range(3)) text_buf.push_back(near_letter());
    do begin
      for (int k = 0; k < n; k++) text_buf.push_back(flip_case(raw_pattern(k)));
      if (n == 0) text_buf.push_back(pick_letter());
    end while (text_buf.size() < goal);
    if (kind >= 88) text_buf[$urandom_range(text_buf.size() - 1)] = near_letter();
    repeat ($urandom_range(3)) text_buf.push_back(near_letter());
  endtask

  task automatic send_text();
    int  sz;
    logic split_end;
    sz = text_buf.size();
    split_end = (sz == 0) || ($urandom_range(9) == 0);
    for (int i = 0; i < sz; i++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      send_item(text_buf[i], 1'b0, !split_end && i == sz - 1);
    end
    if (split_end) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  // registers still at reset values: contains, empty pattern
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h78, 1'b0, 1'b1);
  endtask

  task automatic test_empty_pattern();
    load_config(MODE_EXACT, 1'b0, 6'd0, '0, '0, '0, '0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h71, 1'b0, 1'b1);
  endtask

  // pattern "AbC" against "aBc" and "abcd"
  task automatic test_case_fold();
    load_config(MODE_EXACT, 1'b1, 6'd3, 64'h43_6241, '0, '0, '0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h42, 1'b0, 1'b0);
    send_item(8'h63, 1'b0, 1'b1);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h63, 1'b0, 1'b0);
    send_item(8'h64, 1'b0, 1'b1);
  endtask

  // zero bytes compared literally; empty items in mid-text are dropped
  task automatic test_zero_bytes();
    load_config(MODE_EXACT, 1'b0, 6'd2, 64'hff00, '0, '0, '0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b1);
  endtask

  task automatic test_long_length();
    load_config(MODE_SUFFIX, 1'b0, 6'd63, '1, '1, '1, '1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  // "ab" found under the old pattern must survive a switch to "zz"
  task automatic test_mid_text_config();
    load_config(MODE_PREFIX, 1'b0, 6'd2, 64'h6261, '0, '0, '0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    load_config(MODE_CONTAINS, 1'b0, 6'd2, 64'h7a7a, '0, '0, '0);
    send_item(8'h63, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    load_config(MODE_SUFFIX, 1'b0, 6'd1, 64'h61, '0, '0, '0);
    idle_pct = 0;
    stall_pct = 0;
    hold_asks++;
    repeat (30) begin
      send_item(8'h62, 1'b0, 1'b0);
      send_item(8'h61, 1'b0, 1'b1);
    end
    wait_idle();
  endtask

  task automatic test_random();
    int          target;
    int          len;
    logic [63:0] w [NUM_WORDS];
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      wait_idle();
      case (blk / 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 84; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 84; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (blk == 0) len = MAX_PATTERN_DEF;
      else if (blk == 1) len = $urandom_range(63, MAX_PATTERN_DEF + 1);
      else if (blk == 2) len = 0;
      else if ($urandom_range(4) == 0) len = $urandom_range(63);
      else len = $urandom_range(6, 1);
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        w[k / 8][(k % 8) * 8 +: 8] = (k < len && $urandom_range(7) != 0) ?
                                     pick_letter() : 8'($urandom_range(255));
      end
      load_config(2'(blk % 4), 1'($urandom_range(1)), 6'(len), w[0], w[1], w[2], w[3]);
      target = items_sent + BLOCK_ITEMS;
      while (items_sent < target) begin
        build_text();
        send_text();
      end
    end
  endtask

  initial begin
    foreach (word_q[i]) word_q[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_empty_pattern();
    test_case_fold();
    test_zero_bytes();
    test_long_length();
    test_mid_text_config();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
